>>> rtl/core/mllc_pkg.sv
// Shared types, codes and reset constants for the motion and light linkage controller.
package mllc_pkg;

	localparam int TimeW = 48;
	localparam int DeadW = TimeW + 1;
	localparam int LevelW = 16;
	localparam int HoldW = 24;
	localparam int CfgDataW = 24;
	localparam int CfgIdxW = 2;

	localparam logic [LevelW-1:0] DarkReset = 16'd80;
	localparam logic [LevelW-1:0] BrightReset = 16'd120;
	localparam logic [HoldW-1:0] MotionHoldReset = 24'd5000;
	localparam logic [HoldW-1:0] FreezeReset = 24'd60000;

	typedef enum logic [2:0] {
		FUNC_SENSOR    = 3'd0,
		FUNC_LED_SET   = 3'd1,
		FUNC_CAM_START = 3'd2,
		FUNC_CAM_STOP  = 3'd3,
		FUNC_USER      = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		OWNER_NONE   = 2'd0,
		OWNER_MANUAL = 2'd1,
		OWNER_AUTO   = 2'd2
	} owner_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DARK   = 2'd0,
		REG_BRIGHT = 2'd1,
		REG_HOLD   = 2'd2,
		REG_FREEZE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LevelW-1:0] dark_threshold;
		logic [LevelW-1:0] bright_threshold;
		logic [HoldW-1:0]  motion_hold_ms;
		logic [HoldW-1:0]  manual_freeze_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [TimeW-1:0]  now_ms;
		logic              motion;
		logic [LevelW-1:0] als_level;
		logic              led_request;
	} item_t;

	typedef struct packed {
		logic       start_camera;
		logic       stop_camera;
		logic [1:0] start_owner;
		logic       set_led;
		logic       led_drive;
	} res_t;

endpackage

>>> rtl/core/motion_light_linkage_controller.sv
// Top level: input register, event logic and result register.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | func, now_ms, motion, als_level, led_request
//  out     | output    | out_valid/out_stall| start_camera, stop_camera, start_owner, set_led, led_drive
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall stays low; a result passes the input
// register, then the result register, before it is presented on the out channel.
// All state is updated as an item moves
// from the input register to the result register. Reset clears state and restores
// the register defaults; no clearing pass. An out stall holds the result and
// backs up into in_stall only once the input register is also full.
module motion_light_linkage_controller
	import mllc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          func,
	input  logic [TimeW-1:0]    now_ms,
	input  logic                motion,
	input  logic [LevelW-1:0]   als_level,
	input  logic                led_request,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                start_camera,
	output logic                stop_camera,
	output logic [1:0]          start_owner,
	output logic                set_led,
	output logic                led_drive
);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  out_valid_q;
	res_t  res_q;
	res_t  res;
	logic  advance;
	logic  fire;

	mllc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func        <= func;
			item_s1.now_ms      <= now_ms;
			item_s1.motion      <= motion;
			item_s1.als_level   <= als_level;
			item_s1.led_request <= led_request;
		end
	end

	mllc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign start_camera = res_q.start_camera;
	assign stop_camera  = res_q.stop_camera;
	assign start_owner  = res_q.start_owner;
	assign set_led      = res_q.set_led;
	assign led_drive    = res_q.led_drive;

endmodule

>>> rtl/core/mllc_regs.sv
// Configuration register file: thresholds and hold times.
module mllc_regs
	import mllc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold   <= DarkReset;
			cfg_q.bright_threshold <= BrightReset;
			cfg_q.motion_hold_ms   <= MotionHoldReset;
			cfg_q.manual_freeze_ms <= FreezeReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DARK:   cfg_q.dark_threshold   <= cfg_data[LevelW-1:0];
				REG_BRIGHT: cfg_q.bright_threshold <= cfg_data[LevelW-1:0];
				REG_HOLD:   cfg_q.motion_hold_ms   <= cfg_data[HoldW-1:0];
				REG_FREEZE: cfg_q.manual_freeze_ms <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/mllc_core.sv
// Camera and LED state with the per-event update and result logic.
module mllc_core
	import mllc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  fire,
	output res_t  res
);

	logic             running_q;
	owner_t           owner_q;
	logic [DeadW-1:0] deadline_q;
	logic             led_q;
	logic [DeadW-1:0] freeze_q;

	logic             running_d;
	owner_t           owner_d;
	logic [DeadW-1:0] deadline_d;
	logic             led_d;
	logic [DeadW-1:0] freeze_d;

	logic [DeadW-1:0] now_x;
	logic [DeadW-1:0] hold_sum;
	logic [DeadW-1:0] freeze_sum;

	assign now_x      = {1'b0, item.now_ms};
	assign hold_sum   = now_x + {{(DeadW-HoldW){1'b0}}, cfg.motion_hold_ms};
	assign freeze_sum = now_x + {{(DeadW-HoldW){1'b0}}, cfg.manual_freeze_ms};

	always_comb begin
		running_d  = running_q;
		owner_d    = owner_q;
		deadline_d = deadline_q;
		led_d      = led_q;
		freeze_d   = freeze_q;
		res        = '0;
		case (func_t'(item.func))
			FUNC_SENSOR: begin
				if (item.motion) begin
					deadline_d = hold_sum;
					if (!running_q) begin
						running_d        = 1'b1;
						owner_d          = OWNER_AUTO;
						res.start_camera = 1'b1;
						res.start_owner  = OWNER_AUTO;
					end
				end else if (running_q && owner_q == OWNER_AUTO && now_x >= deadline_q) begin
					running_d       = 1'b0;
					owner_d         = OWNER_NONE;
					res.stop_camera = 1'b1;
				end
				if (now_x >= freeze_q) begin
					if (!led_q && item.als_level <= cfg.dark_threshold) begin
						led_d         = 1'b1;
						res.set_led   = 1'b1;
						res.led_drive = 1'b1;
					end else if (led_q && item.als_level >= cfg.bright_threshold) begin
						led_d       = 1'b0;
						res.set_led = 1'b1;
					end
				end
			end
			FUNC_LED_SET: begin
				led_d = item.led_request;
				if (item.now_ms != '0)
					freeze_d = freeze_sum;
			end
			FUNC_CAM_START, FUNC_USER: begin
				running_d  = 1'b1;
				owner_d    = OWNER_MANUAL;
				deadline_d = '0;
			end
			FUNC_CAM_STOP: begin
				running_d  = 1'b0;
				owner_d    = OWNER_NONE;
				deadline_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			owner_q    <= OWNER_NONE;
			deadline_q <= '0;
			led_q      <= 1'b0;
			freeze_q   <= '0;
		end else if (fire) begin
			running_q  <= running_d;
			owner_q    <= owner_d;
			deadline_q <= deadline_d;
			led_q      <= led_d;
			freeze_q   <= freeze_d;
		end
	end

endmodule

>>> rtl/core/mllc_checker.sv
// Port-level checker for the linkage controller, bound to the top level.
module mllc_checker
	import mllc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       start_camera,
	input logic       stop_camera,
	input logic [1:0] start_owner,
	input logic       set_led,
	input logic       led_drive
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out beat dropped while stalled");

	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(start_camera && stop_camera))
		else $error("start and stop in one beat");

	a_owner_auto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_camera |-> start_owner == OWNER_AUTO)
		else $error("start without auto owner");

	a_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !start_camera |-> start_owner == OWNER_NONE)
		else $error("owner reported without start");

	a_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !set_led |-> !led_drive)
		else $error("led drive without set");

endmodule

bind motion_light_linkage_controller mllc_checker u_mllc_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for motion_light_linkage_controller: random and directed events.
module tb_top;
	import mllc_pkg::*;

	localparam logic [2:0] FuncRsvLo = 3'd5;
	localparam logic [2:0] FuncRsvHi = 3'd7;
	localparam int EventsPerSetting = 200;
	localparam int NumSettings = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	reg_idx_t            cfg_index = REG_DARK;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [2:0]          func = '0;
	logic [TimeW-1:0]    now_ms = '0;
	logic                motion = 1'b0;
	logic [LevelW-1:0]   als_level = '0;
	logic                led_request = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                start_camera;
	logic                stop_camera;
	logic [1:0]          start_owner;
	logic                set_led;
	logic                led_drive;

	// predictor copy of registers and state
	logic [LevelW-1:0] thr_dark;
	logic [LevelW-1:0] thr_bright;
	logic [HoldW-1:0]  hold_ms;
	logic [HoldW-1:0]  freeze_ms;
	logic              cam_on;
	owner_t            cam_owner;
	logic [DeadW-1:0]  auto_dl;
	logic              led_on;
	logic [DeadW-1:0]  freeze_dl;

	item_t            pending_events[$];
	res_t             expected_results[$];
	item_t            on_bus;
	res_t             want;
	logic [TimeW-1:0] clock_ms;
	int               n_err = 0;
	int               n_accepted = 0;
	int               tx_idle_pct = 0;
	int               rx_stall_pct = 0;
	logic             hold_rx = 1'b0;

	motion_light_linkage_controller u_dut (.*);

	always #4 clk = ~clk;

	task automatic report_mismatch(string what);
		$display("mismatch @%0t: %s", $realtime, what);
		n_err++;
	endtask

	task automatic check_field(string name, logic [1:0] got, logic [1:0] exp_v);
		if (got !== exp_v)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_v));
	endtask

	function automatic res_t linkage_step(item_t it);
		res_t r;
		logic [DeadW-1:0] t;
		r = '0;
		t = {1'b0, it.now_ms};
		case (it.func)
			FUNC_SENSOR: begin
				if (it.motion) begin
					auto_dl = t + {{(DeadW-HoldW){1'b0}}, hold_ms};
					if (!cam_on) begin
						cam_on = 1'b1;
						cam_owner = OWNER_AUTO;
						r.start_camera = 1'b1;
						r.start_owner = OWNER_AUTO;
					end
				end else if (cam_on && cam_owner == OWNER_AUTO && t >= auto_dl) begin
					cam_on = 1'b0;
					cam_owner = OWNER_NONE;
					r.stop_camera = 1'b1;
				end
				if (t >= freeze_dl) begin
					if (!led_on && it.als_level <= thr_dark) begin
						led_on = 1'b1;
						r.set_led = 1'b1;
						r.led_drive = 1'b1;
					end else if (led_on && it.als_level >= thr_bright) begin
						led_on = 1'b0;
						r.set_led = 1'b1;
					end
				end
			end
			FUNC_LED_SET: begin
				led_on = it.led_request;
				if (it.now_ms != '0)
					freeze_dl = t + {{(DeadW-HoldW){1'b0}}, freeze_ms};
			end
			FUNC_CAM_START, FUNC_USER: begin
				cam_on = 1'b1;
				cam_owner = OWNER_MANUAL;
				auto_dl = '0;
			end
			FUNC_CAM_STOP: begin
				cam_on = 1'b0;
				cam_owner = OWNER_NONE;
				auto_dl = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic item_t random_event();
		item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 62)
			it.func = FUNC_SENSOR;
		else if (r < 70)
			it.func = FUNC_LED_SET;
		else if (r < 77)
			it.func = FUNC_CAM_START;
		else if (r < 84)
			it.func = FUNC_CAM_STOP;
		else if (r < 90)
			it.func = FUNC_USER;
		else if (r < 96)
			it.func = 3'($urandom_range(FuncRsvLo, FuncRsvHi));
		else
			it.func = 3'($urandom);
		// mostly steady time in steps of 250 ms so deadlines are hit exactly
		r = $urandom_range(0, 99);
		if (r < 3)
			clock_ms = TimeW'({$urandom, $urandom});
		else if (r < 13)
			clock_ms = clock_ms + TimeW'($urandom_range(0, 999));
		else if (r >= 20)
			clock_ms = clock_ms + TimeW'(250 * $urandom_range(0, 16));
		it.now_ms = clock_ms;
		it.motion = $urandom_range(0, 99) < 35;
		case ($urandom_range(0, 5))
			0: it.als_level = thr_dark + LevelW'($urandom_range(0, 2)) - 16'd1;
			1: it.als_level = thr_bright + LevelW'($urandom_range(0, 2)) - 16'd1;
			2: it.als_level = $urandom_range(0, 1) ? '1 : '0;
			default: it.als_level = LevelW'($urandom);
		endcase
		it.led_request = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic add_event(logic [2:0] f, logic [TimeW-1:0] t, logic mo,
			logic [LevelW-1:0] lvl, logic req);
		item_t it;
		it.func = f;
		it.now_ms = t;
		it.motion = mo;
		it.als_level = lvl;
		it.led_request = req;
		pending_events.push_back(it);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_DARK:   thr_dark = val[LevelW-1:0];
			REG_BRIGHT: thr_bright = val[LevelW-1:0];
			REG_HOLD:   hold_ms = val;
			REG_FREEZE: freeze_ms = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(linkage_step(on_bus));
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_events.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					on_bus = pending_events.pop_front();
					in_valid <= 1'b1;
					func <= on_bus.func;
					now_ms <= on_bus.now_ms;
					motion <= on_bus.motion;
					als_level <= on_bus.als_level;
					led_request <= on_bus.led_request;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = expected_results.pop_front();
				check_field("start_camera", {1'b0, start_camera}, {1'b0, want.start_camera});
				check_field("stop_camera", {1'b0, stop_camera}, {1'b0, want.stop_camera});
				check_field("start_owner", start_owner, want.start_owner);
				check_field("set_led", {1'b0, set_led}, {1'b0, want.set_led});
				check_field("led_drive", {1'b0, led_drive}, {1'b0, want.led_drive});
			end
		end
	end

	always @(posedge clk)
		out_stall <= hold_rx || ($urandom_range(0, 99) < rx_stall_pct);

	// long receiver hold-off so the pipe backs up into in_stall
	initial begin
		while (n_accepted < 300)
			@(posedge clk);
		hold_rx <= 1'b1;
		repeat (400) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		thr_dark = DarkReset;
		thr_bright = BrightReset;
		hold_ms = MotionHoldReset;
		freeze_ms = FreezeReset;
		cam_on = 1'b0;
		cam_owner = OWNER_NONE;
		auto_dl = '0;
		led_on = 1'b0;
		freeze_dl = '0;
		clock_ms = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int s = 0; s < NumSettings; s++) begin
			case (s / 2)
				0: begin
					tx_idle_pct = 14;
					rx_stall_pct = 56;
				end
				1: begin
					tx_idle_pct = 56;
					rx_stall_pct = 14;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
			endcase
			case (s)
				0: begin
					write_reg(REG_DARK, CfgDataW'(DarkReset));
					write_reg(REG_BRIGHT, CfgDataW'(BrightReset));
					write_reg(REG_HOLD, MotionHoldReset);
					write_reg(REG_FREEZE, FreezeReset);
				end
				1: begin
					write_reg(REG_DARK, '0);
					write_reg(REG_BRIGHT, '0);
					write_reg(REG_HOLD, '0);
					write_reg(REG_FREEZE, '0);
				end
				2: begin
					write_reg(REG_DARK, '1);
					write_reg(REG_BRIGHT, '1);
					write_reg(REG_HOLD, '1);
					write_reg(REG_FREEZE, '1);
				end
				3: begin
					// dark above bright
					write_reg(REG_DARK, 24'd500);
					write_reg(REG_BRIGHT, 24'd100);
					write_reg(REG_HOLD, CfgDataW'(250 * $urandom_range(0, 8)));
					write_reg(REG_FREEZE, CfgDataW'(250 * $urandom_range(0, 40)));
				end
				default: begin
					write_reg(REG_DARK, CfgDataW'($urandom));
					write_reg(REG_BRIGHT, CfgDataW'($urandom));
					write_reg(REG_HOLD, CfgDataW'(250 * $urandom_range(0, 40)));
					write_reg(REG_FREEZE, CfgDataW'(250 * $urandom_range(0, 400)));
				end
			endcase
			@(posedge clk);
			cfg_we <= 1'b0;

			if (s == 0) begin
				add_event(FUNC_SENSOR, 0, 1'b0, 16'd0, 1'b0);
				add_event(FUNC_SENSOR, 100, 1'b1, 16'hFFFF, 1'b0);
				add_event(FUNC_SENSOR, 200, 1'b1, 16'd80, 1'b0);
				add_event(FUNC_SENSOR, 5199, 1'b0, 16'd119, 1'b1);
				add_event(FUNC_SENSOR, 5200, 1'b0, 16'd120, 1'b0);
				add_event(FUNC_SENSOR, 5300, 1'b0, 16'd81, 1'b0);
				add_event(FUNC_CAM_START, 6000, 1'b1, 16'd0, 1'b1);
				add_event(FUNC_SENSOR, 20000, 1'b0, 16'd0, 1'b0);
				add_event(FUNC_SENSOR, 20100, 1'b1, 16'd200, 1'b0);
				add_event(FUNC_SENSOR, 30000, 1'b0, 16'd200, 1'b0);
				add_event(FUNC_CAM_STOP, 30100, 1'b0, 16'd0, 1'b0);
				add_event(FUNC_USER, 30200, 1'b1, 16'd0, 1'b0);
				add_event(FUNC_SENSOR, 40000, 1'b0, 16'd0, 1'b0);
				add_event(FUNC_CAM_STOP, 40100, 1'b0, 16'd0, 1'b0);
				add_event(FUNC_LED_SET, 0, 1'b0, 16'd0, 1'b1);
				add_event(FUNC_SENSOR, 40300, 1'b0, 16'hFFFF, 1'b0);
				add_event(FUNC_LED_SET, 41000, 1'b0, 16'd0, 1'b1);
				add_event(FUNC_SENSOR, 100999, 1'b0, 16'hFFFF, 1'b0);
				add_event(FUNC_SENSOR, 101000, 1'b0, 16'hFFFF, 1'b0);
				for (int f = FuncRsvLo; f <= FuncRsvHi; f++)
					add_event(3'(f), '1, 1'b1, '1, 1'b1);
				add_event(FUNC_SENSOR, '1, 1'b1, 16'd0, 1'b1);
				add_event(FUNC_SENSOR, '1, 1'b0, 16'd0, 1'b0);
				add_event(FUNC_CAM_STOP, '1, 1'b1, '1, 1'b1);
				clock_ms = 48'd200000;
			end else if (s % 2 == 0) begin
				clock_ms = TimeW'($urandom_range(0, 1000000));
			end else begin
				clock_ms = TimeW'({$urandom, $urandom});
			end
			for (int k = 0; k < EventsPerSetting; k++)
				pending_events.push_back(random_event());
			drain();
		end

		repeat (4) @(posedge clk);
		if (n_err == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/mllc_pkg.sv
rtl/core/mllc_regs.sv
rtl/core/mllc_core.sv
rtl/core/motion_light_linkage_controller.sv
rtl/core/mllc_checker.sv
test/tb_top.sv
